@@ hw/rtl/pmra_pkg.sv @@
`timescale 1ns / 1ps

package pmra_pkg;

    localparam int CH_W    = 15;
    localparam int TB_W    = 3;
    localparam int ADC_W   = 12;
    localparam int COUNT_W = 24;
    localparam int SUM_W   = 36;
    localparam int SQ_W    = 48;
    localparam int RES_W   = 16;
    localparam int MASK_W  = 8;

    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [MASK_W-1:0]  MASK_RESET = '1;

    // register index as decoded from the word address bit
    localparam logic REG_MASK = 1'b0;

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
        logic [SQ_W-1:0]    sq_sum;
    } t_entry;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] n;
        logic [SUM_W-1:0]   s;
        logic [SQ_W-1:0]    q;
    } t_stats_req;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] mean;
        logic [RES_W-1:0] rms;
    } t_stats_rsp;

endpackage

@@ hw/rtl/pmra_stats.sv @@
`timescale 1ns / 1ps

module pmra_stats (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pmra_pkg::t_stats_req i_req,
    output pmra_pkg::t_stats_rsp o_rsp
);
    import pmra_pkg::*;

    localparam int VAR_SHIFT  = 8;
    localparam int MEAN_SHIFT = 4;
    localparam int ACC_W  = COUNT_W + SQ_W + 1;
    localparam int MC_W   = ACC_W - 1;
    localparam int MP_W   = SUM_W;
    localparam int X_W    = MC_W + VAR_SHIFT;
    localparam int ROOT_W = X_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int DVD_W  = ROOT_W;
    localparam int AU_W   = ACC_W;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    localparam logic [CNT_W-1:0] STEPS_NQ   = CNT_W'(COUNT_W);
    localparam logic [CNT_W-1:0] STEPS_SS   = CNT_W'(SUM_W);
    localparam logic [CNT_W-1:0] STEPS_ROOT = CNT_W'(ROOT_W);
    localparam logic [CNT_W-1:0] STEPS_DIV  = CNT_W'(DVD_W);

    typedef enum logic [6:0] {
        E_IDLE     = 7'b0000001,
        E_MUL_NQ   = 7'b0000010,
        E_MUL_SS   = 7'b0000100,
        E_ROOT     = 7'b0001000,
        E_DIV_MEAN = 7'b0010000,
        E_DIV_RMS  = 7'b0100000,
        E_DONE     = 7'b1000000
    } t_eng_state;

    t_eng_state         r_est, n_est;
    logic [COUNT_W-1:0] r_n, n_n;
    logic [SUM_W-1:0]   r_s, n_s;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [MC_W-1:0]    r_mcand, n_mcand;
    logic [MP_W-1:0]    r_mplier, n_mplier;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [X_W-1:0]     r_x, n_x;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [DVD_W-1:0]   r_dvd, n_dvd;
    logic [COUNT_W-1:0] r_drem, n_drem;
    logic [RES_W-1:0]   r_mean, n_mean;
    logic [RES_W-1:0]   r_rms, n_rms;

    // shared add/subtract unit
    logic [AU_W-1:0] au_a, au_b;
    logic            au_sub;
    logic [AU_W:0]   au_sum;
    logic            au_ge;

    logic [REM_W-1:0]   root_t, root_d;
    logic [COUNT_W:0]   div_t;
    logic [ACC_W-1:0]   acc_step;
    logic [DVD_W-1:0]   quo_step;
    logic [COUNT_W-1:0] drem_step;
    logic               last;

    assign root_t = {r_rem[REM_W-3:0], r_x[X_W-1 -: 2]};
    assign root_d = {r_root, 2'b01};
    assign div_t  = {r_drem, r_dvd[DVD_W-1]};

    always_comb begin
        au_a   = '0;
        au_b   = '0;
        au_sub = 1'b0;
        case (r_est)
            E_MUL_NQ: begin
                au_a = r_acc;
                au_b = AU_W'(r_mcand);
            end
            E_MUL_SS: begin
                au_a   = r_acc;
                au_b   = AU_W'(r_mcand);
                au_sub = 1'b1;
            end
            E_ROOT: begin
                au_a   = AU_W'(root_t);
                au_b   = AU_W'(root_d);
                au_sub = 1'b1;
            end
            E_DIV_MEAN, E_DIV_RMS: begin
                au_a   = AU_W'(div_t);
                au_b   = AU_W'(r_n);
                au_sub = 1'b1;
            end
            default: begin
                au_a   = '0;
                au_b   = '0;
                au_sub = 1'b0;
            end
        endcase
    end

    assign au_sum = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)} + (AU_W + 1)'(au_sub);
    assign au_ge  = au_sum[AU_W];

    assign acc_step  = r_mplier[0] ? au_sum[ACC_W-1:0] : r_acc;
    assign quo_step  = {r_dvd[DVD_W-2:0], au_ge};
    assign drem_step = au_ge ? au_sum[COUNT_W-1:0] : div_t[COUNT_W-1:0];
    assign last      = (r_cnt == CNT_W'(1));

    always_comb begin
        n_est    = r_est;
        n_n      = r_n;
        n_s      = r_s;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_x      = r_x;
        n_root   = r_root;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_drem   = r_drem;
        n_mean   = r_mean;
        n_rms    = r_rms;
        case (r_est)
            E_IDLE: begin
                if (i_req.start) begin
                    n_n      = i_req.n;
                    n_s      = i_req.s;
                    n_acc    = '0;
                    n_mcand  = MC_W'(i_req.q);
                    n_mplier = MP_W'(i_req.n);
                    n_cnt    = STEPS_NQ;
                    n_est    = E_MUL_NQ;
                end
            end
            E_MUL_NQ: begin
                n_acc    = acc_step;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - CNT_W'(1);
                if (last) begin
                    n_mcand  = MC_W'(r_s);
                    n_mplier = MP_W'(r_s);
                    n_cnt    = STEPS_SS;
                    n_est    = E_MUL_SS;
                end
            end
            E_MUL_SS: begin
                n_acc    = acc_step;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - CNT_W'(1);
                if (last) begin
                    n_root = '0;
                    n_rem  = '0;
                    if (acc_step[ACC_W-1]) begin
                        // negative variance clamps to zero
                        n_dvd  = DVD_W'({r_s, {MEAN_SHIFT{1'b0}}});
                        n_drem = '0;
                        n_cnt  = STEPS_DIV;
                        n_est  = E_DIV_MEAN;
                    end else begin
                        n_x   = {acc_step[MC_W-1:0], {VAR_SHIFT{1'b0}}};
                        n_cnt = STEPS_ROOT;
                        n_est = E_ROOT;
                    end
                end
            end
            E_ROOT: begin
                n_rem  = au_ge ? au_sum[REM_W-1:0] : root_t;
                n_root = {r_root[ROOT_W-2:0], au_ge};
                n_x    = r_x << 2;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last) begin
                    n_dvd  = DVD_W'({r_s, {MEAN_SHIFT{1'b0}}});
                    n_drem = '0;
                    n_cnt  = STEPS_DIV;
                    n_est  = E_DIV_MEAN;
                end
            end
            E_DIV_MEAN: begin
                n_dvd  = quo_step;
                n_drem = drem_step;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last) begin
                    n_mean = quo_step[RES_W-1:0];
                    n_dvd  = r_root;
                    n_drem = '0;
                    n_cnt  = STEPS_DIV;
                    n_est  = E_DIV_RMS;
                end
            end
            E_DIV_RMS: begin
                n_dvd  = quo_step;
                n_drem = drem_step;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last) begin
                    n_rms = (|quo_step[DVD_W-1:RES_W]) ? '1 : quo_step[RES_W-1:0];
                    n_est = E_DONE;
                end
            end
            E_DONE: begin
                n_est = E_IDLE;
            end
            default: begin
                n_est = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= E_IDLE;
        end else begin
            r_est <= n_est;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_s      <= n_s;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_cnt    <= n_cnt;
        r_x      <= n_x;
        r_root   <= n_root;
        r_rem    <= n_rem;
        r_dvd    <= n_dvd;
        r_drem   <= n_drem;
        r_mean   <= n_mean;
        r_rms    <= n_rms;
    end

    assign o_rsp.done = (r_est == E_DONE);
    assign o_rsp.mean = r_mean;
    assign o_rsp.rms  = r_rms;

endmodule

@@ hw/rtl/pedestal_mean_rms_accumulator_top.sv @@
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_op, i_channel, i_time_bin, i_adc
// result    out        o_out_valid / i_out_stall    o_out_channel, o_out_time_bin,
//                                                   o_sample_count, o_mean_value,
//                                                   o_rms_value, o_has_data
// config    in         APB psel/penable/pready      paddr, pwdata, prdata
//
// Accumulate item: a store read on accept, then a write back in S_UPD unless rejected.
// Query with data: runs on the shared 73-bit add/sub unit: 24 + 36 shift-add steps
// for n*q - s*s, 40 root steps, two 40-step divides; an empty entry skips them all.
// Reset: the store is cleared one entry a cycle, all NUM_CHANNELS * NUM_TIME_BINS entries
// (262144 by default); o_in_stall stays high meanwhile, config writes are taken.
// A result waits in the output register; the next item is accepted meanwhile.
`timescale 1ns / 1ps

module pedestal_mean_rms_accumulator_top #(
    parameter int NUM_CHANNELS  = 32768,
    parameter int NUM_TIME_BINS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [0:0]                     i_op,
    input  logic [pmra_pkg::CH_W-1:0]      i_channel,
    input  logic [pmra_pkg::TB_W-1:0]      i_time_bin,
    input  logic [pmra_pkg::ADC_W-1:0]     i_adc,

    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pmra_pkg::CH_W-1:0]      o_out_channel,
    output logic [pmra_pkg::TB_W-1:0]      o_out_time_bin,
    output logic [pmra_pkg::COUNT_W-1:0]   o_sample_count,
    output logic [pmra_pkg::RES_W-1:0]     o_mean_value,
    output logic [pmra_pkg::RES_W-1:0]     o_rms_value,
    output logic                           o_has_data,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pmra_pkg::APB_AW-1:0]    paddr,
    input  logic [pmra_pkg::APB_DW-1:0]    pwdata,
    output logic [pmra_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import pmra_pkg::*;

    localparam int DEPTH = NUM_CHANNELS * NUM_TIME_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IDX_W = CH_W + $clog2(NUM_TIME_BINS) + 1;
    localparam int SQR_W = 2 * ADC_W;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_UPD    = 6'b000100,
        S_QRY    = 6'b001000,
        S_CALC   = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]     r_clr_addr;
    logic [MASK_W-1:0] r_mask;
    logic              r_out_valid, n_out_valid;

    t_entry            r_mem [DEPTH];
    t_entry            r_rd_data;

    logic [CH_W-1:0]   r_ch;
    logic [TB_W-1:0]   r_tb;
    logic [ADC_W-1:0]  r_adc;
    logic [SQR_W-1:0]  r_adc_sq;
    logic              r_hit;
    logic [AW-1:0]     r_idx;

    logic [COUNT_W-1:0] r_res_count;
    logic [RES_W-1:0]   r_res_mean, r_res_rms;
    logic               r_res_has;

    logic [CH_W-1:0]    r_out_channel;
    logic [TB_W-1:0]    r_out_time_bin;
    logic [COUNT_W-1:0] r_out_count;
    logic [RES_W-1:0]   r_out_mean, r_out_rms;
    logic               r_out_has;

    logic              in_accept;
    logic              in_hit;
    logic [IDX_W-1:0]  idx_full;
    logic [AW-1:0]     in_idx;
    logic              clr_last;
    logic              acc_ok;
    logic              q_hit;
    logic              out_free;
    logic              apb_wr;

    logic              st_we;
    logic [AW-1:0]     st_addr;
    t_entry            st_wdata;
    t_entry            upd_entry;

    t_stats_req        stats_req;
    t_stats_rsp        stats_rsp;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign in_hit   = (32'(i_channel) < NUM_CHANNELS) && (32'(i_time_bin) < NUM_TIME_BINS);
    assign idx_full = IDX_W'(i_channel) * IDX_W'(NUM_TIME_BINS) + IDX_W'(i_time_bin);
    assign in_idx   = in_hit ? idx_full[AW-1:0] : '0;

    assign clr_last = (r_clr_addr == AW'(DEPTH - 1));

    assign acc_ok = r_hit && (r_tb != '0) && r_mask[r_tb] && (r_adc != '0)
                    && (r_rd_data.count != COUNT_MAX);
    assign q_hit  = r_hit && (r_rd_data.count != '0);

    assign out_free = !r_out_valid || !i_out_stall;

    assign upd_entry.count  = r_rd_data.count + COUNT_W'(1);
    assign upd_entry.sum    = r_rd_data.sum + SUM_W'(r_adc);
    assign upd_entry.sq_sum = r_rd_data.sq_sum + SQ_W'(r_adc_sq);

    assign st_we    = (r_state == S_CLEAR) || ((r_state == S_UPD) && acc_ok);
    assign st_addr  = (r_state == S_CLEAR) ? r_clr_addr : r_idx;
    assign st_wdata = (r_state == S_CLEAR) ? '0 : upd_entry;

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_mem[st_addr] <= st_wdata;
        end
        if (in_accept) begin
            r_rd_data <= r_mem[in_idx];
        end
    end

    assign stats_req.start = (r_state == S_QRY) && q_hit;
    assign stats_req.n     = r_rd_data.count;
    assign stats_req.s     = r_rd_data.sum;
    assign stats_req.q     = r_rd_data.sq_sum;

    pmra_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (stats_req),
        .o_rsp   (stats_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_accept) n_state = (i_op == OP_ACCUM) ? S_UPD : S_QRY;
            end
            S_UPD: begin
                n_state = S_IDLE;
            end
            S_QRY: begin
                n_state = q_hit ? S_CALC : S_RESULT;
            end
            S_CALC: begin
                if (stats_rsp.done) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if ((r_state == S_RESULT) && out_free) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_mask      <= MASK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (apb_wr && (paddr[APB_AW-1] == REG_MASK)) begin
                r_mask <= pwdata[MASK_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch     <= i_channel;
            r_tb     <= i_time_bin;
            r_adc    <= i_adc;
            r_adc_sq <= SQR_W'(i_adc) * SQR_W'(i_adc);
            r_hit    <= in_hit;
            r_idx    <= in_idx;
        end
        if (r_state == S_QRY) begin
            r_res_count <= q_hit ? r_rd_data.count : '0;
            r_res_has   <= q_hit;
            r_res_mean  <= '0;
            r_res_rms   <= '0;
        end
        if ((r_state == S_CALC) && stats_rsp.done) begin
            r_res_mean <= stats_rsp.mean;
            r_res_rms  <= stats_rsp.rms;
        end
        if ((r_state == S_RESULT) && out_free) begin
            r_out_channel  <= r_ch;
            r_out_time_bin <= r_tb;
            r_out_count    <= r_res_count;
            r_out_mean     <= r_res_mean;
            r_out_rms      <= r_res_rms;
            r_out_has      <= r_res_has;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_channel  = r_out_channel;
    assign o_out_time_bin = r_out_time_bin;
    assign o_sample_count = r_out_count;
    assign o_mean_value   = r_out_mean;
    assign o_rms_value    = r_out_rms;
    assign o_has_data     = r_out_has;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1] == REG_MASK) ? APB_DW'(r_mask) : '0;

    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(st_we && in_accept))
        else $error("store write collides with item accept");

    a_accum_goes_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_op == OP_ACCUM)) |=> (r_state == S_UPD))
        else $error("accumulate item did not enter write back");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_data) |-> ((o_mean_value == '0) && (o_rms_value == '0)))
        else $error("empty entry reports nonzero statistics");

    a_count_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_sample_count != '0) == o_has_data))
        else $error("has_data disagrees with sample count");

endmodule
